FILE: hdl/udpck_pkg.sv
`timescale 1ns / 1ps

package udpck_pkg;

  localparam int MAX_FRAME_BYTES = 2048;
  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

  localparam logic [POS_W-1:0] MAX_POS     = POS_W'(MAX_FRAME_BYTES);
  localparam logic [POS_W-1:0] ADDR_POS    = POS_W'(26);
  localparam logic [POS_W-1:0] ADDR_END    = POS_W'(37);
  localparam logic [POS_W-1:0] UDP_HDR_POS = POS_W'(34);
  localparam logic [POS_W-1:0] PAYLOAD_POS = POS_W'(42);

  localparam logic [15:0] PROTO_WORD = 16'h0011;

  typedef struct packed {
    logic [15:0] sum;
    logic [15:0] len2;
    logic        short_frame;
  } fin_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

FILE: hdl/udp_ipv4_frame_checksum.sv
`timescale 1ns / 1ps

// channel | ports                         | contents
// --------+-------------------------------+-------------------------------
// in      | in_tvalid/in_tready/in_tdata  | tdata[7:0] data_byte,
//         | in_tlast                      | tlast last_byte
// out     | out_tvalid/out_tready         | tdata[15:0] udp_checksum,
//         | out_tdata/out_tuser           | tuser short_frame
//
// One byte per cycle is taken unless stalled; results pass fin_r to the output register.
// The rate is set by the 16-bit end-around add on the running sum, at most one per byte.
// The final pseudo-header adds sit in their own stage before the output register.
// Synchronous active-low reset clears the valid flag of every stage and the frame state.
// A stalled output holds the result; input stalls only when a last byte meets full stages.

module udp_ipv4_frame_checksum (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] udp_checksum
  output logic        out_tuser   // [0] short_frame
);

  logic            in_valid_r;
  logic [7:0]      in_data_r;
  logic            in_last_r;
  logic            go;
  logic            fin_ready;
  udpck_pkg::fin_t fin;

  assign go        = in_valid_r && (!in_last_r || fin_ready);
  assign in_tready = !in_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  udpck_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .data_byte (in_data_r),
    .last_byte (in_last_r),
    .fin       (fin)
  );

  udpck_final u_final (
    .clk        (clk),
    .rst_n      (rst_n),
    .fin_valid  (go && in_last_r),
    .fin_in     (fin),
    .fin_ready  (fin_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_go_valid: assert property (@(posedge clk) disable iff (!rst_n)
    go |-> in_valid_r)
    else $error("byte processed without a held transfer");

endmodule

FILE: hdl/udpck_accum.sv
`timescale 1ns / 1ps

module udpck_accum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output udpck_pkg::fin_t     fin
);

  logic [udpck_pkg::POS_W-1:0] pos_r;
  logic [udpck_pkg::POS_W-1:0] pos_nxt;
  logic [udpck_pkg::POS_W-1:0] len_w;
  logic [15:0]                 sum_r;
  logic [15:0]                 sum_nxt;
  logic [7:0]                  pend_r;
  logic [15:0]                 word;
  logic [15:0]                 len16;
  logic                        in_range;
  logic                        summed;
  logic                        odd;

  always_comb begin
    in_range = pos_r < udpck_pkg::MAX_POS;
    summed   = (pos_r >= udpck_pkg::ADDR_POS && pos_r <= udpck_pkg::ADDR_END) ||
               pos_r >= udpck_pkg::PAYLOAD_POS;
    odd      = pos_r[0];
    word     = odd ? {pend_r, data_byte} : {data_byte, 8'h00};
    sum_nxt  = (in_range && summed && (odd || last_byte)) ?
               udpck_pkg::oc_add(sum_r, word) : sum_r;
    pos_nxt  = in_range ? pos_r + 1'b1 : pos_r;
    len_w    = pos_nxt - udpck_pkg::UDP_HDR_POS;
    len16    = 16'(len_w);
    fin.sum         = sum_nxt;
    fin.len2        = {len16[14:0], len16[15]};
    fin.short_frame = pos_nxt < udpck_pkg::PAYLOAD_POS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sum_r  <= '0;
      pend_r <= '0;
    end else if (go) begin
      if (last_byte) begin
        pos_r  <= '0;
        sum_r  <= '0;
        pend_r <= '0;
      end else begin
        pos_r <= pos_nxt;
        sum_r <= sum_nxt;
        if (in_range && summed && !odd) begin
          pend_r <= data_byte;
        end
      end
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= udpck_pkg::MAX_POS)
    else $error("byte counter beyond frame limit");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    go && last_byte |=> pos_r == '0 && sum_r == '0)
    else $error("state not cleared after last byte");

endmodule

FILE: hdl/udpck_final.sv
`timescale 1ns / 1ps

module udpck_final (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fin_valid,
  input  udpck_pkg::fin_t fin_in,
  output logic            fin_ready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [15:0]     out_tdata,
  output logic            out_tuser
);

  udpck_pkg::fin_t fin_r;
  logic            fin_valid_r;
  logic            out_valid_r;
  logic [15:0]     cks_r;
  logic            short_r;
  logic            out_open;
  logic [15:0]     s1;
  logic [15:0]     s2;
  logic [15:0]     cks_nxt;

  assign out_open  = !out_valid_r || out_tready;
  assign fin_ready = !fin_valid_r || out_open;

  always_comb begin
    s1      = udpck_pkg::oc_add(fin_r.sum, udpck_pkg::PROTO_WORD);
    s2      = udpck_pkg::oc_add(s1, fin_r.len2);
    cks_nxt = fin_r.short_frame ? 16'h0000 : ~s2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_ready) begin
        fin_valid_r <= fin_valid;
      end
      if (out_open) begin
        out_valid_r <= fin_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && fin_valid) begin
      fin_r <= fin_in;
    end
    if (out_open && fin_valid_r) begin
      cks_r   <= cks_nxt;
      short_r <= fin_r.short_frame;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = cks_r;
  assign out_tuser  = short_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid |-> fin_ready)
    else $error("result offered to a full stage");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 16'h0000)
    else $error("short frame with nonzero checksum");

endmodule

FILE: test/udp_ipv4_frame_checksum_tb.sv
`timescale 1ns / 1ps

module udp_ipv4_frame_checksum_tb;

  localparam int MAX_FRAME_BYTES = udpck_pkg::MAX_FRAME_BYTES;

  localparam int ADDR_FIRST   = 26;
  localparam int ADDR_LAST    = 37;
  localparam int UDP_HDR_AT   = 34;
  localparam int PAYLOAD_AT   = 42;
  localparam int IDLE_PCT     = 21;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    logic [15:0] cks;
    logic        shrt;
  } udp_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;

  udp_result_t expected_q[$];
  logic [7:0]  frame_q[$];

  int          frame_pos;
  logic [15:0] word_sum;
  logic [7:0]  high_byte;
  logic [15:0] last_cks;

  bit          steady;
  int          errors;
  int          cycles;
  int          bytes_sent;
  int          frames_sent;
  int          results_checked;
  int          short_seen;
  int          long_seen;

  udp_ipv4_frame_checksum uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d checksums outstanding", cycles,
               expected_q.size());
      $display("** udp_ipv4_frame_checksum: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
    int s;
    s = int'(a) + int'(b);
    if (s > 32'hFFFF) s = s - 32'hFFFF;
    return s[15:0];
  endfunction

  // fold one accepted byte into the running checksum; on the last byte queue the expected result
  function automatic void absorb_byte(logic [7:0] b, logic last);
    udp_result_t r;
    logic [15:0] len;
    logic [15:0] s;
    if (frame_pos < MAX_FRAME_BYTES) begin
      if ((frame_pos >= ADDR_FIRST && frame_pos <= ADDR_LAST) || frame_pos >= PAYLOAD_AT) begin
        if (frame_pos % 2 == 0) begin
          high_byte = b;
          if (last) word_sum = ones_add(word_sum, {b, 8'h00});
        end else begin
          word_sum = ones_add(word_sum, {high_byte, b});
        end
      end
      frame_pos++;
    end
    if (last) begin
      if (frame_pos < PAYLOAD_AT) begin
        r.cks  = 16'h0000;
        r.shrt = 1'b1;
      end else begin
        len    = 16'(frame_pos - UDP_HDR_AT);
        s      = ones_add(word_sum, udpck_pkg::PROTO_WORD);
        s      = ones_add(s, len);
        s      = ones_add(s, len);
        r.cks  = ~s;
        r.shrt = 1'b0;
      end
      expected_q.push_back(r);
      last_cks  = r.cks;
      frame_pos = 0;
      word_sum  = 16'h0000;
      high_byte = 8'h00;
    end
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("t=%0t mismatch %s: got 0x%04h, expected 0x%04h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    udp_result_t r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected checksum", out_tdata, 16'h0000);
      end else begin
        r = expected_q.pop_front();
        if (out_tdata !== r.cks) report_mismatch("udp_checksum", out_tdata, r.cks);
        if (out_tuser !== r.shrt) report_mismatch("short_frame", 16'(out_tuser), 16'(r.shrt));
        results_checked++;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    absorb_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int n;
    n = frame_q.size();
    for (int i = 0; i < n; i++) send_byte(frame_q[i], i == n - 1);
    frames_sent++;
    if (n < PAYLOAD_AT) short_seen++;
    if (n > MAX_FRAME_BYTES) long_seen++;
  endtask

  // fill < 0 selects random bytes
  task automatic build_frame(int len, int fill);
    frame_q.delete();
    for (int i = 0; i < len; i++)
      frame_q.push_back(fill < 0 ? 8'($urandom_range(255)) : 8'(fill));
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic test_short_frames();
    int lens[5] = '{1, 2, 26, 38, 41};
    foreach (lens[i]) begin
      build_frame(lens[i], -1);
      send_frame();
    end
    drain();
  endtask

  task automatic test_boundary_lengths();
    build_frame(42, 8'hFF); send_frame();
    build_frame(43, 8'hFF); send_frame();
    build_frame(44, 8'h00); send_frame();
    build_frame(43, -1);    send_frame();
    build_frame(64, 8'h00); send_frame();
    build_frame(65, 8'hFF); send_frame();
    drain();
  endtask

  task automatic test_zero_checksum();
    build_frame(60, -1);
    frame_q[42] = 8'h00;
    frame_q[43] = 8'h00;
    send_frame();
    // feed the checksum back as a payload word: the sum becomes all ones
    frame_q[42] = last_cks[15:8];
    frame_q[43] = last_cks[7:0];
    send_frame();
    drain();
  endtask

  task automatic test_overlong_frames();
    steady = 1'b1;
    build_frame(MAX_FRAME_BYTES + 1, -1);
    send_frame();
    steady = 1'b0;
    drain();
  endtask

  task automatic test_random_frames();
    int start_bytes;
    int start_results;
    int pick;
    int k;
    start_bytes   = bytes_sent;
    start_results = frames_sent;
    k = 0;
    while (bytes_sent - start_bytes < 500 || frames_sent - start_results < 10) begin
      pick = $urandom_range(99);
      if (pick < 70) build_frame($urandom_range(100, PAYLOAD_AT), -1);
      else if (pick < 85) build_frame($urandom_range(PAYLOAD_AT - 1, 1), -1);
      else build_frame($urandom_range(300, 101), -1);
      steady = (k >= 4 && k < 8);
      send_frame();
      if (k == 8) drain();
      k++;
    end
    steady = 1'b0;
    drain();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    steady     = 1'b0;
    errors     = 0;
    cycles     = 0;
    frame_pos  = 0;
    word_sum   = 16'h0000;
    high_byte  = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_short_frames();
    test_boundary_lengths();
    test_zero_checksum();
    test_overlong_frames();
    test_random_frames();

    repeat (10) @(posedge clk);
    $display("sent %0d frames (%0d short, %0d overlong), %0d bytes", frames_sent, short_seen,
             long_seen, bytes_sent);
    $display("compared %0d checksums, %0d mismatches", results_checked, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("** udp_ipv4_frame_checksum: PASSED **");
    end else begin
      $display("** udp_ipv4_frame_checksum: FAILED **");
    end
    $finish;
  end

endmodule
